FILE: rtl/core/hpcd_pkg.sv
// Shared types and constants for the prefix code decoder.
`timescale 1ns / 1ps

package hpcd_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 4;
	localparam int SYM_W     = 8;
	localparam int PAD_W     = 4;
	localparam int ACT_W     = 2;
	localparam int S_TDATA_W = 32;
	localparam int ENTRY_W   = SYM_W + 1;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD   = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_DECODE = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_FLUSH
	} state_t;

endpackage

FILE: rtl/core/huffman_prefix_code_decoder.sv
// Top level of the table-driven prefix code decoder.
//
//  channel  dir  handshake          contents
//  s_*      in   s_tvalid/s_tready  tuser action, tlast final byte, tdata load/decode fields
//  m_*      out  m_tvalid/m_tready  tdata symbol, tuser bad code, tlast last of transaction
//
// Decode byte: one table read per bit; the bit loop is bounded by the table read
// feeding the next address. Load writes one entry when its length is valid. Clear
// sweeps every table entry, one entry swept per cycle. After reset the same sweep
// runs before s_tready rises. A full output register with a further result pending
// stalls the bit loop.
`timescale 1ns / 1ps

module huffman_prefix_code_decoder #(
	parameter int MAX_CODE_LENGTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// code_value[7:0], code_length[11:8], symbol_value[19:12], data_byte[27:20],
	// pad_count[31:28]
	input  logic [hpcd_pkg::S_TDATA_W-1:0] s_tdata,
	// action[1:0]
	input  logic [hpcd_pkg::ACT_W-1:0]     s_tuser,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// decoded_symbol[7:0]
	output logic [hpcd_pkg::SYM_W-1:0]     m_tdata,
	// bad_code[0]
	output logic                           m_tuser,
	output logic                           m_tlast
);

	import hpcd_pkg::*;

	localparam int AW  = MAX_CODE_LENGTH + 1;
	localparam int TW  = AW + BYTE_W;
	localparam int PLW = $clog2(MAX_CODE_LENGTH + 1);

	state_t                     state_q, state_d;
	logic [AW-1:0]              clr_q;
	logic [BYTE_W-1:0]          byte_q, byte_nx;
	logic [3:0]                 cnt_q, cnt_nx;
	logic [3:0]                 nbits_q;
	logic                       fin_q;
	logic [MAX_CODE_LENGTH-1:0] pend_code_q, pend_code_nx;
	logic [PLW-1:0]             pend_len_q, pend_len_nx;
	logic                       hold_v_q, hold_v_nx;
	logic [SYM_W-1:0]           hold_sym_q, hold_sym_nx;
	logic                       hold_bad_q, hold_bad_nx;
	logic                       m_tvalid_q;
	logic [SYM_W-1:0]           m_tdata_q;
	logic                       m_tuser_q, m_tlast_q;

	logic                       s_acc;
	action_t                    act;
	logic [BYTE_W-1:0]          in_code;
	logic [LEN_W-1:0]           in_len;
	logic [SYM_W-1:0]           in_sym;
	logic [BYTE_W-1:0]          in_byte;
	logic [PAD_W-1:0]           in_pad, pad_sat;
	logic [3:0]                 nb_in;
	logic                       len_ok;
	logic [TW-1:0]              ld_tmp, rd_tmp;
	logic [MAX_CODE_LENGTH-1:0] cand_code, nx_code;
	logic [PLW-1:0]             cand_len, nx_len;
	logic [ENTRY_W-1:0]         rd_data;
	logic                       hit, badc, res, out_free, last_bit, stall;
	logic                       we;
	logic [AW-1:0]              waddr, raddr;
	logic [ENTRY_W-1:0]         wdata;
	logic                       push, push_last;
	logic                       nb_ld, fin_ld;

	assign s_acc   = s_tvalid && s_tready;
	assign act     = action_t'(s_tuser);
	assign in_code = s_tdata[7:0];
	assign in_len  = s_tdata[11:8];
	assign in_sym  = s_tdata[19:12];
	assign in_byte = s_tdata[27:20];
	assign in_pad  = s_tdata[31:28];
	assign pad_sat = (in_pad > 4'd8) ? 4'd8 : in_pad;
	assign nb_in   = s_tlast ? (4'd8 - pad_sat) : 4'd8;
	assign len_ok  = (in_len != '0) && (in_len <= LEN_W'(MAX_CODE_LENGTH));

	assign ld_tmp = (TW'(1) << in_len) | (TW'(in_code) & ((TW'(1) << in_len) - TW'(1)));

	assign cand_code = (MAX_CODE_LENGTH)'({pend_code_q, byte_q[BYTE_W-1]});
	assign cand_len  = pend_len_q + PLW'(1);
	assign hit       = rd_data[ENTRY_W-1];
	assign badc      = !hit && (cand_len >= PLW'(MAX_CODE_LENGTH));
	assign res       = hit || badc;
	assign out_free  = !m_tvalid_q || m_tready;
	assign last_bit  = (cnt_q == nbits_q - 4'd1);
	assign stall     = res && hold_v_q && !out_free;

	// next bit's table address from the updated pending code
	assign nx_code = (MAX_CODE_LENGTH)'({pend_code_nx, byte_nx[BYTE_W-1]});
	assign nx_len  = pend_len_nx + PLW'(1);
	assign rd_tmp  = (TW'(1) << nx_len) | TW'(nx_code);
	assign raddr   = rd_tmp[AW-1:0];

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		byte_nx      = byte_q;
		cnt_nx       = cnt_q;
		pend_code_nx = pend_code_q;
		pend_len_nx  = pend_len_q;
		hold_v_nx    = hold_v_q;
		hold_sym_nx  = hold_sym_q;
		hold_bad_nx  = hold_bad_q;
		push         = 1'b0;
		push_last    = 1'b0;
		we           = 1'b0;
		waddr        = clr_q;
		wdata        = '0;
		nb_ld        = 1'b0;
		fin_ld       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_acc) begin
					case (act)
						ACT_LOAD: begin
							we    = len_ok;
							waddr = ld_tmp[AW-1:0];
							wdata = {1'b1, in_sym};
						end
						ACT_CLEAR: begin
							state_d = ST_CLEAR;
						end
						ACT_DECODE: begin
							byte_nx = in_byte;
							cnt_nx  = '0;
							nb_ld   = 1'b1;
							fin_ld  = 1'b1;
							if (nb_in == '0) begin
								if (s_tlast) begin
									pend_code_nx = '0;
									pend_len_nx  = '0;
								end
							end else begin
								state_d = ST_DECODE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DECODE: begin
				if (!stall) begin
					if (res) begin
						push         = hold_v_q;
						hold_v_nx    = 1'b1;
						hold_sym_nx  = hit ? rd_data[SYM_W-1:0] : '0;
						hold_bad_nx  = badc;
						pend_code_nx = '0;
						pend_len_nx  = '0;
					end else begin
						pend_code_nx = cand_code;
						pend_len_nx  = cand_len;
					end
					byte_nx = byte_q << 1;
					cnt_nx  = cnt_q + 4'd1;
					if (last_bit) begin
						if (fin_q) begin
							pend_code_nx = '0;
							pend_len_nx  = '0;
						end
						state_d = (res || hold_v_q) ? ST_FLUSH : ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					hold_v_nx = 1'b0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			nbits_q     <= '0;
			fin_q       <= 1'b0;
			pend_code_q <= '0;
			pend_len_q  <= '0;
			hold_v_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= (state_q == ST_CLEAR) ? clr_q + AW'(1) : '0;
			cnt_q       <= cnt_nx;
			pend_code_q <= pend_code_nx;
			pend_len_q  <= pend_len_nx;
			hold_v_q    <= hold_v_nx;
			if (nb_ld) begin
				nbits_q <= nb_in;
			end
			if (fin_ld) begin
				fin_q <= s_tlast;
			end
			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_q     <= byte_nx;
		hold_sym_q <= hold_sym_nx;
		hold_bad_q <= hold_bad_nx;
		if (push) begin
			m_tdata_q <= hold_sym_q;
			m_tuser_q <= hold_bad_q;
			m_tlast_q <= push_last;
		end
	end

	hpcd_ram #(
		.AW(AW),
		.DW(ENTRY_W)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_flush_has_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> hold_v_q)
		else $error("flush without held result");

	a_pend_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pend_len_q < PLW'(MAX_CODE_LENGTH)))
		else $error("pending code reached max length at rest");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECODE) |-> (cnt_q < nbits_q))
		else $error("bit counter past used bits");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into occupied output register");
`endif

endmodule

FILE: rtl/core/hpcd_ram.sv
// Code table storage: one write port, one registered read port.
`timescale 1ns / 1ps

module hpcd_ram #(
	parameter int AW = 9,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
